// File: rtl/core/tccur_pkg.sv
`default_nettype none

package tccur_pkg;

  // Field widths of the ports.
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 12;
  localparam int SCREEN_W = 13;
  localparam int CELL_W   = 6;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Tab stops fall on multiples of TAB_STOP columns (a power of two here).
  localparam int TAB_STOP = 8;
  localparam int TAB_BITS = $clog2(TAB_STOP);
  // At most this many placements come from one request.
  localparam int MAX_RUN  = 8;
  localparam int RUN_W    = $clog2(MAX_RUN + 1);
  localparam int TABCNT_W = $clog2(TAB_STOP + 1) + 1;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

  // Command kinds.
  localparam logic [1:0] KIND_GLYPH   = 2'd0;
  localparam logic [1:0] KIND_TAB     = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 3'd5;

  // Register reset values.
  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [CELL_W-1:0]   RST_CELL_WIDTH    = 6'd8;
  localparam logic [CELL_W-1:0]   RST_CELL_HEIGHT   = 6'd16;
  localparam logic [COLOR_W-1:0]  RST_FORE_COLOR    = 32'h00ff_ffff;
  localparam logic [COLOR_W-1:0]  RST_BACK_COLOR    = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic run_busy;
    logic place;
  } back_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tccur_front.sv
`default_nettype none

module tccur_front (
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [tccur_pkg::CHAR_W-1:0] char_code,
  input  wire tccur_pkg::fifo_stat_t     fifo_stat,
  output logic                           push,
  output tccur_pkg::cmd_t                push_cmd
);
  import tccur_pkg::*;

  // A request is taken whenever the queue has room.
  assign in_ready = !fifo_stat.full;
  assign push     = in_valid && !fifo_stat.full;

  always_comb begin
    push_cmd.code = char_code;
    if (char_code == CODE_NEWLINE) begin
      push_cmd.kind = KIND_NEWLINE;
    end else if (char_code == CODE_TAB) begin
      push_cmd.kind = KIND_TAB;
    end else begin
      push_cmd.kind = KIND_GLYPH;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tccur_fifo.sv
`default_nettype none

module tccur_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tccur_pkg::cmd_t       push_cmd,
  input  wire logic                  pop,
  output tccur_pkg::cmd_t            head,
  output tccur_pkg::fifo_stat_t      stat
);
  import tccur_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign head       = entries[rd_ptr];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tccur_back.sv
`default_nettype none

module tccur_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tccur_pkg::cmd_t                  head,
  input  wire tccur_pkg::fifo_stat_t            fifo_stat,
  output logic                                  pop,
  input  wire logic [tccur_pkg::SCREEN_W-1:0]   screen_width,
  input  wire logic [tccur_pkg::SCREEN_W-1:0]   screen_height,
  input  wire logic [tccur_pkg::CELL_W-1:0]     cell_width,
  input  wire logic [tccur_pkg::CELL_W-1:0]     cell_height,
  input  wire logic [tccur_pkg::COLOR_W-1:0]    fore_color,
  input  wire logic [tccur_pkg::COLOR_W-1:0]    back_color,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tccur_pkg::POS_W-1:0]           origin_x,
  output logic [tccur_pkg::POS_W-1:0]           origin_y,
  output logic [tccur_pkg::CHAR_W-1:0]          glyph_code,
  output logic [tccur_pkg::COLOR_W-1:0]         draw_fore,
  output logic [tccur_pkg::COLOR_W-1:0]         draw_back,
  output logic                                  last_of_run,
  output tccur_pkg::back_stat_t                 stat
);
  import tccur_pkg::*;

  localparam int PROD_W = SCREEN_W + CELL_W;

  logic [POS_W-1:0]    cursor_col;
  logic [POS_W-1:0]    cursor_row;
  logic [POS_W-1:0]    cursor_col_next;
  logic [POS_W-1:0]    cursor_row_next;
  logic [RUN_W-1:0]    run;
  logic [RUN_W-1:0]    run_next;

  logic                run_active;
  logic                head_places;
  logic                can_place;
  logic                place;
  logic [CHAR_W-1:0]   place_code;
  logic                place_last;
  logic [TABCNT_W-1:0] tab_raw;
  logic [RUN_W-1:0]    tab_count;
  logic [POS_W-1:0]    col_adv;
  logic [POS_W-1:0]    row_adv;
  logic [PROD_W-1:0]   col_reach;
  logic [PROD_W-1:0]   row_reach;
  logic                col_over;
  logic                row_over;
  logic [POS_W-1:0]    row_after_nl;
  logic [POS_W+CELL_W-1:0] pix_x;
  logic [POS_W+CELL_W-1:0] pix_y;

  always_comb begin
    run_active  = (run != '0);
    head_places = !fifo_stat.empty && (head.kind != KIND_NEWLINE);
    can_place   = !out_valid || out_ready;
    place       = can_place && (run_active || head_places);
    pop         = !run_active && !fifo_stat.empty &&
                  ((head.kind == KIND_NEWLINE) || can_place);

    // Spaces to the next tab stop, capped at the longest run.
    tab_raw = TABCNT_W'(TAB_STOP) - TABCNT_W'(cursor_col[TAB_BITS-1:0]);
    if (tab_raw > TABCNT_W'(MAX_RUN)) begin
      tab_count = RUN_W'(MAX_RUN);
    end else begin
      tab_count = RUN_W'(tab_raw);
    end

    if (run_active) begin
      place_code = CODE_SPACE;
      place_last = (run == RUN_W'(1));
    end else if (head.kind == KIND_TAB) begin
      place_code = CODE_SPACE;
      place_last = (tab_count == RUN_W'(1));
    end else begin
      place_code = head.code;
      place_last = 1'b1;
    end

    // Fit tests: the next cell must end inside the screen.
    col_adv   = cursor_col + 1'b1;
    row_adv   = cursor_row + 1'b1;
    col_reach = (PROD_W'(col_adv) + 1'b1) * PROD_W'(cell_width);
    row_reach = (PROD_W'(row_adv) + 1'b1) * PROD_W'(cell_height);
    col_over  = col_reach > PROD_W'(screen_width);
    row_over  = row_reach > PROD_W'(screen_height);
    row_after_nl = row_over ? '0 : row_adv;

    pix_x = cursor_col * cell_width;
    pix_y = cursor_row * cell_height;

    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (place) begin
      if (col_over) begin
        cursor_col_next = '0;
        cursor_row_next = row_after_nl;
      end else begin
        cursor_col_next = col_adv;
      end
    end else if (pop && head.kind == KIND_NEWLINE) begin
      cursor_col_next = '0;
      cursor_row_next = row_after_nl;
    end

    run_next = run;
    if (run_active && place) begin
      run_next = run - 1'b1;
    end else if (pop && head.kind == KIND_TAB) begin
      run_next = tab_count - 1'b1;
    end
  end

  assign stat.run_busy = run_active;
  assign stat.place    = place;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      run        <= '0;
      out_valid  <= 1'b0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      run        <= run_next;
      if (place) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      origin_x    <= pix_x[POS_W-1:0];
      origin_y    <= pix_y[POS_W-1:0];
      glyph_code  <= place_code;
      draw_fore   <= fore_color;
      draw_back   <= back_color;
      last_of_run <= place_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/text_console_cursor.sv
`default_nettype none

// Cursor keeper of a framebuffer text console.
// Character bytes arrive on the input channel (in_valid, in_ready,
// char_code), one request per byte. Each glyph placement leaves on the
// output channel (out_valid, out_ready and the placement fields). A newline
// moves the cursor and places nothing. A tab places one to eight spaces,
// and the last placement of every request has last_of_run set.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the screen size, the cell size and the two colors. It is always
// ready, and it should only be used while the block is idle.
// An accepted byte is written into the command queue, and its first
// placement is registered in the output register when the back takes it.
// Ordinary characters sustain one placement per cycle while the receiver
// is ready; a tab holds the back end while it places its spaces, which sets
// the rate for tab-heavy text, and the two-entry command queue lets the
// input keep taking bytes meanwhile until the queue fills.
// When the receiver stalls, the output register holds its placement and
// the queue fills; then in_ready falls until the stall clears.
// Reset clears the cursor to column 0, row 0, empties the queue and the
// output, and restores the registers to their default values.
module text_console_cursor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tccur_pkg::CHAR_W-1:0]       char_code,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tccur_pkg::POS_W-1:0]             origin_x,
  output logic [tccur_pkg::POS_W-1:0]             origin_y,
  output logic [tccur_pkg::CHAR_W-1:0]            glyph_code,
  output logic [tccur_pkg::COLOR_W-1:0]           draw_fore,
  output logic [tccur_pkg::COLOR_W-1:0]           draw_back,
  output logic                                    last_of_run,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tccur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tccur_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tccur_pkg::*;

  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [CELL_W-1:0]   cell_width;
  logic [CELL_W-1:0]   cell_height;
  logic [COLOR_W-1:0]  fore_color;
  logic [COLOR_W-1:0]  back_color;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  fifo_stat_t fifo_stat;
  back_stat_t back_stat;

  // The register file takes a write in every cycle; indexes past the
  // list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      cell_width    <= RST_CELL_WIDTH;
      cell_height   <= RST_CELL_HEIGHT;
      fore_color    <= RST_FORE_COLOR;
      back_color    <= RST_BACK_COLOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[SCREEN_W-1:0];
        REG_CELL_WIDTH:    cell_width    <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT:   cell_height   <= cfg_data[CELL_W-1:0];
        REG_FORE_COLOR:    fore_color    <= cfg_data[COLOR_W-1:0];
        REG_BACK_COLOR:    back_color    <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies each byte into a command for the queue.
  tccur_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tccur_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  // The back owns the cursor, expands tabs and drives the output register.
  tccur_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .cell_width    (cell_width),
    .cell_height   (cell_height),
    .fore_color    (fore_color),
    .back_color    (back_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .glyph_code    (glyph_code),
    .draw_fore     (draw_fore),
    .draw_back     (draw_back),
    .last_of_run   (last_of_run),
    .stat          (back_stat)
  );

  // The queue never holds more commands than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.count <= QCNT_W'(QDEPTH))
    else $error("command queue count exceeds its depth");

  // While a tab run is in progress no further command leaves the queue.
  a_run_holds_queue: assert property (@(posedge clk) disable iff (rst)
    back_stat.run_busy |-> !pop)
    else $error("command popped during a tab run");

  // A new placement appears only after the back made one.
  a_out_from_place: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_stat.place))
    else $error("output became valid without a placement");

endmodule

`default_nettype wire

// File: tb/text_console_cursor_tb.sv
`timescale 1ns / 100ps

import tccur_pkg::*;

// One glyph placement as it leaves the block.
typedef struct packed {
  logic [POS_W-1:0]   origin_x;
  logic [POS_W-1:0]   origin_y;
  logic [CHAR_W-1:0]  glyph_code;
  logic [COLOR_W-1:0] draw_fore;
  logic [COLOR_W-1:0] draw_back;
  logic               last_of_run;
} placement_t;

// Tracks the console cursor and the registers, and works out the placements
// that each accepted character must produce. Results are checked in order.
class placement_scoreboard;
  int unsigned        screen_w;
  int unsigned        screen_h;
  int unsigned        cell_w;
  int unsigned        cell_h;
  logic [COLOR_W-1:0] fore;
  logic [COLOR_W-1:0] back;
  int unsigned        col;
  int unsigned        row;
  placement_t         expected_q[$];
  int                 errors;

  function new();
    screen_w = RST_SCREEN_WIDTH;
    screen_h = RST_SCREEN_HEIGHT;
    cell_w   = RST_CELL_WIDTH;
    cell_h   = RST_CELL_HEIGHT;
    fore     = RST_FORE_COLOR;
    back     = RST_BACK_COLOR;
    col      = 0;
    row      = 0;
    errors   = 0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SCREEN_WIDTH:  screen_w = data[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: screen_h = data[SCREEN_W-1:0];
      REG_CELL_WIDTH:    cell_w   = data[CELL_W-1:0];
      REG_CELL_HEIGHT:   cell_h   = data[CELL_W-1:0];
      REG_FORE_COLOR:    fore     = data[COLOR_W-1:0];
      REG_BACK_COLOR:    back     = data[COLOR_W-1:0];
      default: ;
    endcase
  endfunction

  // Column 0 of the next row; the row returns to 0 when the next one would
  // not fit inside the bottom edge.
  function void next_row();
    col = 0;
    row = (row + 1) % (1 << POS_W);
    if ((row + 1) * cell_h > screen_h) row = 0;
  endfunction

  function void place_glyph(logic [CHAR_W-1:0] code, logic last);
    placement_t p;
    p.origin_x    = POS_W'(col * cell_w);
    p.origin_y    = POS_W'(row * cell_h);
    p.glyph_code  = code;
    p.draw_fore   = fore;
    p.draw_back   = back;
    p.last_of_run = last;
    expected_q.push_back(p);
    col = (col + 1) % (1 << POS_W);
    if ((col + 1) * cell_w > screen_w) next_row();
  endfunction

  function void note_char(logic [CHAR_W-1:0] code);
    int unsigned run;
    if (code == CODE_NEWLINE) begin
      next_row();
    end else if (code != CODE_TAB) begin
      place_glyph(code, 1'b1);
    end else begin
      // The space count is fixed once, before any of the spaces wrap.
      run = TAB_STOP - col % TAB_STOP;
      if (run > MAX_RUN) run = MAX_RUN;
      for (int k = 0; k < run; k++) place_glyph(CODE_SPACE, k == run - 1);
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_placement(placement_t got);
    placement_t want;
    if (expected_q.size() == 0) begin
      $error("placement with none expected: origin_x=%0d origin_y=%0d glyph_code=%0d",
             got.origin_x, got.origin_y, got.glyph_code);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("origin_x", want.origin_x, got.origin_x);
    compare_field("origin_y", want.origin_y, got.origin_y);
    compare_field("glyph_code", want.glyph_code, got.glyph_code);
    compare_field("draw_fore", want.draw_fore, got.draw_fore);
    compare_field("draw_back", want.draw_back, got.draw_back);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module text_console_cursor_tb;

  // A run that goes this many cycles without any handshake is hung.
  localparam int WATCHDOG_LIMIT    = 3000;
  // Quiet cycles after the last placement, so that a trailing newline has
  // certainly gone through the two-entry queue before registers change.
  localparam int SETTLE_CYCLES     = 16;
  // Length of the receiver's long hold-off that fills the block up.
  localparam int LONG_HOLD         = 300;
  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 24;
  // Random requests are split into three idling modes by their count.
  localparam int MODE_SWAP_AT      = 75;
  localparam int QUIET_AT          = 150;
  localparam int PRESSURE_AT       = 170;

  typedef struct {
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
    logic [CELL_W-1:0]   glyph_w;
    logic [CELL_W-1:0]   glyph_h;
    logic [COLOR_W-1:0]  fg;
    logic [COLOR_W-1:0]  bg;
  } console_setting_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic [CHAR_W-1:0]     char_code = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic [POS_W-1:0]      origin_x;
  logic [POS_W-1:0]      origin_y;
  logic [CHAR_W-1:0]     glyph_code;
  logic [COLOR_W-1:0]    draw_fore;
  logic [COLOR_W-1:0]    draw_back;
  logic                  last_of_run;
  logic                  cfg_ready;

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 27;
  int recv_idle_pct = 81;
  // Each increment of hold_seq asks the receiver for one long hold-off.
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_cnt      = 0;
  int quiet_cycles  = 0;

  placement_scoreboard sb;

  text_console_cursor dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .glyph_code  (glyph_code),
    .draw_fore   (draw_fore),
    .draw_back   (draw_back),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // Receiver. It stalls at random at the current rate, except during a long
  // hold-off, which it counts down on its own while the sender keeps going.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_cnt  <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. All handshakes are sampled at the rising edge, before any of
  // the values driven at that edge take effect. Register writes are taken
  // first, then requests, then placements.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_char(char_code);
      if (out_valid && out_ready)
        sb.check_placement({origin_x, origin_y, glyph_code, draw_fore, draw_back,
                            last_of_run});
    end
  end

  // Watchdog on cycles without progress on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_console_cursor_tb: done, errors");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that back-to-back requests never drop it; it only falls
  // when the sender decides to idle, or when a phase ends.
  task automatic send_char(input logic [CHAR_W-1:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register write; valid stays high across consecutive writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register. The size registers get random bits above their
  // width, which the block must ignore.
  task automatic apply_setting(input console_setting_t s);
    write_reg(REG_SCREEN_WIDTH, ($urandom() & ~((1 << SCREEN_W) - 1)) | s.scr_w);
    write_reg(REG_SCREEN_HEIGHT, ($urandom() & ~((1 << SCREEN_W) - 1)) | s.scr_h);
    write_reg(REG_CELL_WIDTH, ($urandom() & ~((1 << CELL_W) - 1)) | s.glyph_w);
    write_reg(REG_CELL_HEIGHT, ($urandom() & ~((1 << CELL_W) - 1)) | s.glyph_h);
    write_reg(REG_FORE_COLOR, s.fg);
    write_reg(REG_BACK_COLOR, s.bg);
    cfg_valid <= 1'b0;
  endtask

  // Ends a phase: the input goes quiet, every expected placement must come
  // out, and then the block gets time to finish any trailing newline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly ordinary bytes over the full range, with plenty of tabs and
  // newlines so that runs, wraps and the bottom edge come up often.
  function automatic logic [CHAR_W-1:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return CODE_NEWLINE;
    if (pick < 30) return CODE_TAB;
    return CHAR_W'($urandom_range(255));
  endfunction

  initial begin
    console_setting_t  settings [NUM_SETTINGS];
    logic [CHAR_W-1:0] reset_chars [$];
    logic [CHAR_W-1:0] small_chars [$];
    int                issued;

    sb = new();

    // Settings in the order they are applied. The small screen comes first,
    // with directed text that wraps at the right edge, splits a tab across
    // rows and returns from the bottom edge. The oversized registers leave
    // the cursor far out, so the next small screen starts outside its edges.
    // Zero screen sizes wrap after every glyph; zero cell sizes never wrap
    // and keep every origin at 0.
    settings[0] = '{13'd40, 13'd48, 6'd8, 6'd16, $urandom(), $urandom()};
    settings[1] = '{13'd8191, 13'd8191, 6'd63, 6'd63, 32'hffff_ffff, 32'h0000_0000};
    settings[2] = '{13'd100, 13'd60, 6'd7, 6'd9, $urandom(), $urandom()};
    settings[3] = '{13'd0, 13'd0, 6'd1, 6'd1, 32'h0000_0000, 32'hffff_ffff};
    settings[4] = '{13'd4096, 13'd4096, 6'd0, 6'd0, $urandom(), $urandom()};
    settings[5] = '{13'd1, 13'd1, 6'd1, 6'd1, $urandom(), $urandom()};
    settings[6] = '{13'd4096, 13'd4096, 6'd32, 6'd32, $urandom(), $urandom()};
    settings[7] = '{13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                    6'($urandom_range(32, 1)), 6'($urandom_range(32, 1)),
                    $urandom(), $urandom()};

    // At the reset setting: byte extremes, a tab from the middle of a stop,
    // tabs from column 0 and from a full stop, and newlines.
    reset_chars = '{8'd65, 8'd0, 8'd255, CODE_TAB, CODE_NEWLINE, CODE_TAB, CODE_TAB,
                    CODE_NEWLINE, 8'd127, 8'd128, CODE_SPACE, 8'd85, 8'd170};
    // At the small screen of five columns and three rows.
    small_chars = '{CODE_NEWLINE, 8'd88, 8'd89, 8'd90, 8'd91, 8'd92, CODE_TAB,
                    CODE_NEWLINE, CODE_NEWLINE, 8'd33, 8'd34, CODE_TAB};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_chars[i]) send_char(reset_chars[i]);
    drain();

    issued = 0;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      apply_setting(settings[s]);
      if (s == 0) begin
        foreach (small_chars[i]) send_char(small_chars[i]);
      end
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // Slow receiver first, then slow sender, then full speed.
        if (issued < MODE_SWAP_AT) begin
          send_idle_pct = 27;
          recv_idle_pct = 81;
        end else if (issued < QUIET_AT) begin
          send_idle_pct = 81;
          recv_idle_pct = 27;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // At full speed, the receiver stops for a long time while requests
        // keep coming, so the queue fills and the input must stall.
        if (issued == PRESSURE_AT) hold_seq <= hold_seq + 1;
        send_char(random_char());
        issued++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("text_console_cursor_tb: done, clean");
    else
      $display("text_console_cursor_tb: done, errors");
    $finish;
  end

endmodule
